>>> hw/rtl/rotating_seed_escape_time_iteration_defines.svh
// Assertion macros used by the checker file.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ROTATING_SEED_ESCAPE_TIME_ITERATION_DEFINES_SVH
`define ROTATING_SEED_ESCAPE_TIME_ITERATION_DEFINES_SVH

// Same-cycle implication.
`define RSEI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RSEI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/rsei_pkg.sv
package rsei_pkg;

	localparam int DATA_W       = 32;
	localparam int REM_W        = 16;
	localparam int MODE_W       = 2;
	localparam int CFG_IDX_W    = 3;
	localparam int WIDE_W       = 66;
	localparam int PROD_W       = 64;
	localparam int ESCAPE_LIMIT = 4;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_RE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_IM  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_XX   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_XY   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_YX   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_YY   = 3'd7;

	localparam logic [MODE_W-1:0] MODE_MANDEL  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_JULIA   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_JULIA_B = 2'd2;

	localparam logic [REM_W-1:0] MAX_ITER_RESET = 16'd255;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic [REM_W-1:0]         max_iterations;
		logic signed [DATA_W-1:0] seed_re;
		logic signed [DATA_W-1:0] seed_im;
		logic signed [DATA_W-1:0] rot_xx;
		logic signed [DATA_W-1:0] rot_xy;
		logic signed [DATA_W-1:0] rot_yx;
		logic signed [DATA_W-1:0] rot_yy;
	} cfg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] zx;
		logic signed [DATA_W-1:0] zy;
		logic signed [DATA_W-1:0] cx;
		logic signed [DATA_W-1:0] cy;
		logic [REM_W-1:0]         budget;
	} job_t;

	function automatic logic signed [WIDE_W-1:0] ext_prod(input logic signed [PROD_W-1:0] v);
		return {{(WIDE_W - PROD_W){v[PROD_W-1]}}, v};
	endfunction

	function automatic logic signed [WIDE_W-1:0] ext_data(input logic signed [DATA_W-1:0] v);
		return {{(WIDE_W - DATA_W){v[DATA_W-1]}}, v};
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [WIDE_W-1:0] v);
		logic [WIDE_W-DATA_W:0] top;
		top = v[WIDE_W-1:DATA_W-1];
		if (top == '0 || top == '1) begin
			return v[DATA_W-1:0];
		end else if (v[WIDE_W-1]) begin
			return {1'b1, {(DATA_W - 1){1'b0}}};
		end else begin
			return {1'b0, {(DATA_W - 1){1'b1}}};
		end
	endfunction

endpackage

>>> hw/rtl/rsei_ifs.sv
interface rsei_point_if;
	import rsei_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] point_re;
	logic signed [DATA_W-1:0] point_im;
	modport source (output valid, output point_re, output point_im, input ready);
	modport sink (input valid, input point_re, input point_im, output ready);
endinterface

interface rsei_result_if;
	import rsei_pkg::*;
	logic             valid;
	logic             ready;
	logic [REM_W-1:0] remaining;
	modport source (output valid, output remaining, input ready);
	modport sink (input valid, input remaining, output ready);
endinterface

>>> hw/rtl/rsei_front.sv
module rsei_front (
	input  rsei_pkg::cfg_t cfg,
	rsei_point_if.sink     points,
	input  logic           full,
	output logic           push,
	output rsei_pkg::job_t job
);
	import rsei_pkg::*;

	assign points.ready = !full;
	assign push         = points.valid && !full;

	always_comb begin
		job.budget = cfg.max_iterations;
		case (cfg.mode)
			MODE_JULIA: begin
				job.zx = points.point_re;
				job.zy = points.point_im;
				job.cx = cfg.seed_re;
				job.cy = cfg.seed_im;
			end
			MODE_JULIA_B: begin
				job.zx = cfg.seed_re;
				job.zy = cfg.seed_im;
				job.cx = points.point_re;
				job.cy = points.point_im;
			end
			default: begin
				job.zx = points.point_re;
				job.zy = points.point_im;
				job.cx = points.point_re;
				job.cy = points.point_im;
			end
		endcase
	end
endmodule

>>> hw/rtl/rsei_fifo.sv
module rsei_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rsei_pkg::job_t push_job,
	input  logic           pop,
	output rsei_pkg::job_t head,
	output logic           full,
	output logic           empty
);
	import rsei_pkg::*;

	job_t                slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;

	assign full  = count_q == QUEUE_CW'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

>>> hw/rtl/rsei_engine.sv
module rsei_engine #(
	parameter int FRAC_BITS,
	parameter int COUNT_WIDTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rsei_pkg::cfg_t cfg,
	input  rsei_pkg::job_t head,
	input  logic           empty,
	output logic           pop,
	rsei_result_if.source  results
);
	import rsei_pkg::*;

	localparam int               MASK_BITS  = (COUNT_WIDTH < REM_W) ? COUNT_WIDTH : REM_W;
	localparam logic [REM_W-1:0] REM_MASK   = REM_W'((17'd1 << MASK_BITS) - 17'd1);
	localparam logic [PROD_W:0]  ESC_LIMIT  = (PROD_W + 1)'(ESCAPE_LIMIT) << FRAC_BITS;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_ADD  = 4'b0100,
		ST_OUT  = 4'b1000
	} eng_state_t;

	eng_state_t state_q;
	eng_state_t state_d;

	logic signed [DATA_W-1:0] zx_q, zy_q, cx_q, cy_q;
	logic [REM_W-1:0]         left_q;
	logic [REM_W-1:0]         res_q;
	logic                     res_valid_q;

	logic signed [PROD_W-1:0] sq_x_s1, sq_y_s1, cross_s1;
	logic signed [PROD_W-1:0] pxx_s1, pxy_s1, pyx_s1, pyy_s1;

	logic signed [PROD_W-1:0] sx, sy, half_cross;
	logic signed [WIDE_W-1:0] row_x, row_y;
	logic signed [DATA_W-1:0] nzx, nzy, ncx, ncy;
	logic                     escape;
	logic                     slot_free;
	logic                     load_res;

	assign sx         = sq_x_s1 >>> FRAC_BITS;
	assign sy         = sq_y_s1 >>> FRAC_BITS;
	assign half_cross = cross_s1 >>> (FRAC_BITS - 1);
	assign escape     = ({1'b0, sx} + {1'b0, sy}) > ESC_LIMIT;
	assign nzx        = sat_data(ext_prod(sx) - ext_prod(sy) + ext_data(cx_q));
	assign nzy        = sat_data(ext_prod(half_cross) + ext_data(cy_q));
	assign row_x      = ext_prod(pxx_s1) + ext_prod(pxy_s1);
	assign row_y      = ext_prod(pyx_s1) + ext_prod(pyy_s1);
	assign ncx        = sat_data(row_x >>> FRAC_BITS);
	assign ncy        = sat_data(row_y >>> FRAC_BITS);

	assign slot_free       = !res_valid_q || results.ready;
	assign load_res        = (state_q == ST_OUT) && slot_free;
	assign pop             = (state_q == ST_IDLE) && !empty;
	assign results.valid   = res_valid_q;
	assign results.remaining = res_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!empty) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = (left_q == '0) ? ST_OUT : ST_ADD;
			end
			ST_ADD: begin
				state_d = escape ? ST_OUT : ST_MUL;
			end
			ST_OUT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			zx_q   <= head.zx;
			zy_q   <= head.zy;
			cx_q   <= head.cx;
			cy_q   <= head.cy;
			left_q <= head.budget;
		end
		if (state_q == ST_MUL) begin
			sq_x_s1  <= zx_q * zx_q;
			sq_y_s1  <= zy_q * zy_q;
			cross_s1 <= zx_q * zy_q;
			pxx_s1   <= cfg.rot_xx * cx_q;
			pxy_s1   <= cfg.rot_xy * cy_q;
			pyx_s1   <= cfg.rot_yx * cx_q;
			pyy_s1   <= cfg.rot_yy * cy_q;
		end
		if (state_q == ST_ADD && !escape) begin
			zx_q   <= nzx;
			zy_q   <= nzy;
			cx_q   <= ncx;
			cy_q   <= ncy;
			left_q <= left_q - 1'b1;
		end
		if (load_res) begin
			res_q <= left_q & REM_MASK;
		end
	end
endmodule

>>> hw/rtl/rotating_seed_escape_time_iteration.sv
// Escape-time iterator for one complex point per transfer: z = z*z + c in signed
// fixed point with FRAC_BITS fraction bits, values saturating to 32 bits, with c
// multiplied by the rot_* matrix after every step that does not escape; the result
// is the budget left when |z|^2 exceeds 4, or 0 when the budget runs out. Points
// enter a two-entry queue after their start values are picked by mode, so up to
// two points can wait while one is iterated and one result waits to be taken. A
// point holds the iteration engine while it is loaded, then for each step and the
// final escape test through a state of seven 32x32 products and a state of shift,
// add, saturate and escape compare (a spent budget skips the second), and then
// while its result is handed over. Write the configuration only while no point is
// in flight.
module rotating_seed_escape_time_iteration #(
	parameter int FRAC_BITS   = 28,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [rsei_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rsei_pkg::DATA_W-1:0]     cfg_data,
	rsei_point_if.sink                      points,
	rsei_result_if.source                   results
);
	import rsei_pkg::*;

	localparam logic signed [DATA_W-1:0] ONE_VALUE =
		(FRAC_BITS < DATA_W - 1) ? DATA_W'(64'd1 << FRAC_BITS) : {1'b0, {(DATA_W - 1){1'b1}}};

	cfg_t cfg_q;
	job_t push_job;
	job_t head;
	logic push;
	logic pop;
	logic full;
	logic empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode           <= MODE_MANDEL;
			cfg_q.max_iterations <= MAX_ITER_RESET;
			cfg_q.seed_re        <= '0;
			cfg_q.seed_im        <= '0;
			cfg_q.rot_xx         <= ONE_VALUE;
			cfg_q.rot_xy         <= '0;
			cfg_q.rot_yx         <= '0;
			cfg_q.rot_yy         <= ONE_VALUE;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MODE:     cfg_q.mode           <= cfg_data[MODE_W-1:0];
				REG_MAX_ITER: cfg_q.max_iterations <= cfg_data[REM_W-1:0];
				REG_SEED_RE:  cfg_q.seed_re        <= cfg_data;
				REG_SEED_IM:  cfg_q.seed_im        <= cfg_data;
				REG_ROT_XX:   cfg_q.rot_xx         <= cfg_data;
				REG_ROT_XY:   cfg_q.rot_xy         <= cfg_data;
				REG_ROT_YX:   cfg_q.rot_yx         <= cfg_data;
				REG_ROT_YY:   cfg_q.rot_yy         <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rsei_front u_front (
		.cfg    (cfg_q),
		.points (points),
		.full   (full),
		.push   (push),
		.job    (push_job)
	);

	rsei_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	rsei_engine #(
		.FRAC_BITS   (FRAC_BITS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (head),
		.empty   (empty),
		.pop     (pop),
		.results (results)
	);
endmodule

>>> hw/rtl/rsei_checker.sv
`include "rotating_seed_escape_time_iteration_defines.svh"

module rsei_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_write,
	input logic [rsei_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [rsei_pkg::DATA_W-1:0]     cfg_data,
	input logic                            points_valid,
	input logic                            points_ready,
	input logic                            results_valid,
	input logic                            results_ready,
	input logic [rsei_pkg::REM_W-1:0]      results_remaining
);
	import rsei_pkg::*;

	localparam int CAPACITY = QUEUE_DEPTH + 2;
	localparam int OUT_CW   = $clog2(CAPACITY + 1);

	logic [OUT_CW-1:0] outstanding_q;
	logic [REM_W-1:0]  budget_q;
	logic              in_xfer;
	logic              out_xfer;

	assign in_xfer  = points_valid && points_ready;
	assign out_xfer = results_valid && results_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
			budget_q      <= MAX_ITER_RESET;
		end else begin
			if (in_xfer && !out_xfer) begin
				outstanding_q <= outstanding_q + 1'b1;
			end else if (out_xfer && !in_xfer) begin
				outstanding_q <= outstanding_q - 1'b1;
			end
			if (cfg_write && cfg_index == REG_MAX_ITER) begin
				budget_q <= cfg_data[REM_W-1:0];
			end
		end
	end

	`RSEI_ASSERT_NEXT(a_result_held, results_valid && !results_ready, results_valid, "result dropped while stalled")
	`RSEI_ASSERT_NEXT(a_result_stable, results_valid && !results_ready, $stable(results_remaining), "stalled result changed")
	`RSEI_ASSERT_NOW(a_no_spurious, results_valid, outstanding_q != '0, "result without a pending point")
	`RSEI_ASSERT_NOW(a_in_budget, results_valid, results_remaining <= budget_q, "remaining exceeds the budget")
	`RSEI_ASSERT_NOW(a_capacity, 1'b1, outstanding_q <= OUT_CW'(CAPACITY), "more points in flight than storage")
endmodule

bind rotating_seed_escape_time_iteration rsei_checker u_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.cfg_write         (cfg_write),
	.cfg_index         (cfg_index),
	.cfg_data          (cfg_data),
	.points_valid      (points.valid),
	.points_ready      (points.ready),
	.results_valid     (results.valid),
	.results_ready     (results.ready),
	.results_remaining (results.remaining)
);

>>> bench/rotating_seed_escape_time_iteration_tb.sv
`timescale 1ns / 1ps

module rotating_seed_escape_time_iteration_tb;
	import rsei_pkg::*;

	localparam int FRAC = 28;
	localparam int ONE = 1 << FRAC;
	localparam int HOLD_CYCLES = 3000;
	localparam int IDLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1900;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;

	typedef logic signed [WIDE_W-1:0] wide_t;

	localparam wide_t WIDE_HI = 64'sd2147483647;
	localparam wide_t WIDE_LO = -64'sd2147483648;
	localparam wide_t ESCAPE_BOUND = ESCAPE_LIMIT << FRAC;

	class escape_scoreboard;
		cfg_t cfg;
		logic [REM_W-1:0] due[$];
		int mismatches;

		function new();
			cfg.mode = MODE_MANDEL;
			cfg.max_iterations = MAX_ITER_RESET;
			cfg.seed_re = '0;
			cfg.seed_im = '0;
			cfg.rot_xx = ONE;
			cfg.rot_xy = '0;
			cfg.rot_yx = '0;
			cfg.rot_yy = ONE;
			mismatches = 0;
		endfunction

		function wide_t clamp32(wide_t v);
			if (v > WIDE_HI)
				return WIDE_HI;
			if (v < WIDE_LO)
				return WIDE_LO;
			return v;
		endfunction

		function logic [REM_W-1:0] predict_remaining(logic signed [DATA_W-1:0] re,
				logic signed [DATA_W-1:0] im);
			wide_t zx, zy, cx, cy, sx, sy, next_zx, next_cx;
			wide_t rxx, rxy, ryx, ryy;
			logic [REM_W-1:0] left;
			rxx = $signed(cfg.rot_xx);
			rxy = $signed(cfg.rot_xy);
			ryx = $signed(cfg.rot_yx);
			ryy = $signed(cfg.rot_yy);
			case (cfg.mode)
				MODE_JULIA: begin
					zx = re;
					zy = im;
					cx = $signed(cfg.seed_re);
					cy = $signed(cfg.seed_im);
				end
				MODE_JULIA_B: begin
					zx = $signed(cfg.seed_re);
					zy = $signed(cfg.seed_im);
					cx = re;
					cy = im;
				end
				default: begin
					zx = re;
					zy = im;
					cx = re;
					cy = im;
				end
			endcase
			left = cfg.max_iterations;
			while (left != 0) begin
				sx = (zx * zx) >>> FRAC;
				sy = (zy * zy) >>> FRAC;
				if (sx + sy > ESCAPE_BOUND)
					break;
				next_zx = clamp32(sx - sy + cx);
				zy = clamp32((((zx * zy) <<< 1) >>> FRAC) + cy);
				zx = next_zx;
				next_cx = clamp32((rxx * cx + rxy * cy) >>> FRAC);
				cy = clamp32((ryx * cx + ryy * cy) >>> FRAC);
				cx = next_cx;
				left--;
			end
			return left;
		endfunction

		function void note_point(logic signed [DATA_W-1:0] re, logic signed [DATA_W-1:0] im);
			due.push_back(predict_remaining(re, im));
		endfunction

		function void check_count(logic [REM_W-1:0] got);
			logic [REM_W-1:0] want;
			if (due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("remaining count %0d arrived with none outstanding", got);
				return;
			end
			want = due.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("remaining mismatch: expected %0d, got %0d", want, got);
			end
		endfunction

		function int pending();
			return due.size();
		endfunction

		function bit failed();
			return mismatches != 0 || due.size() != 0;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;
	bit steady = 1'b0;
	bit hold_results = 1'b0;

	rsei_point_if point_bus();
	rsei_result_if count_bus();

	escape_scoreboard sb = new();

	rotating_seed_escape_time_iteration #(
		.FRAC_BITS(FRAC),
		.COUNT_WIDTH(REM_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.points(point_bus),
		.results(count_bus)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		if (r < 99)
			return $urandom_range(4, 20);
		return $urandom_range(50, 200);
	endfunction

	function automatic logic [DATA_W-1:0] rand_coord();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(0, 5 * (ONE / 2) * 2) - 5 * (ONE / 2);
		if (r < 80)
			return $urandom_range(0, ONE) - ONE / 2;
		if (r < 95)
			return $urandom;
		case ($urandom_range(0, 3))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] rand_coef();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return $urandom_range(0, 2 * ONE) - ONE;
		if (r < 70) begin
			case ($urandom_range(0, 2))
				0: return ONE;
				1: return -ONE;
				default: return '0;
			endcase
		end
		if (r < 90)
			return $urandom;
		return $urandom_range(0, 1) ? Q_MIN : Q_MAX;
	endfunction

	task automatic write_config(input cfg_t c);
		logic [CFG_IDX_W-1:0] order[8];
		logic [DATA_W-1:0] word;
		order = '{REG_MODE, REG_MAX_ITER, REG_SEED_RE, REG_SEED_IM,
			REG_ROT_XX, REG_ROT_XY, REG_ROT_YX, REG_ROT_YY};
		for (int i = 0; i < 8; i++) begin
			word = $urandom;
			case (order[i])
				REG_MODE: word[MODE_W-1:0] = c.mode;
				REG_MAX_ITER: word[REM_W-1:0] = c.max_iterations;
				REG_SEED_RE: word = c.seed_re;
				REG_SEED_IM: word = c.seed_im;
				REG_ROT_XX: word = c.rot_xx;
				REG_ROT_XY: word = c.rot_xy;
				REG_ROT_YX: word = c.rot_yx;
				default: word = c.rot_yy;
			endcase
			cfg_write <= 1'b1;
			cfg_index <= order[i];
			cfg_data <= word;
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		sb.cfg = c;
	endtask

	task automatic send_point(input logic [DATA_W-1:0] re, input logic [DATA_W-1:0] im);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			point_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point_bus.valid <= 1'b1;
		point_bus.point_re <= re;
		point_bus.point_im <= im;
		do @(posedge clk); while (!point_bus.ready);
	endtask

	task automatic drain();
		point_bus.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (point_bus.valid && point_bus.ready)
				sb.note_point(point_bus.point_re, point_bus.point_im);
			if (count_bus.valid && count_bus.ready)
				sb.check_count(count_bus.remaining);
		end
	end

	initial begin
		count_bus.ready <= 1'b0;
		forever begin
			if (hold_results) begin
				hold_results = 1'b0;
				count_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (steady) begin
				count_bus.ready <= 1'b1;
				@(posedge clk);
			end else begin
				int gap;
				count_bus.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				gap = pick_gap();
				if (gap > 0) begin
					count_bus.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((point_bus.valid && point_bus.ready) || (count_bus.valid && count_bus.ready))
				idle = 0;
			else
				idle++;
		end
		$display("rotating_seed_escape_time_iteration_tb failed");
		$finish;
	end

	initial begin
		cfg_t c;
		int n, sent, phase;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_data <= '0;
		point_bus.valid <= 1'b0;
		point_bus.point_re <= '0;
		point_bus.point_im <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: bounded points, escape boundary, saturating corners
		send_point(0, 0);
		send_point(2 * ONE, 0);
		send_point(-2 * ONE, 0);
		send_point(Q_MAX, Q_MAX);
		send_point(Q_MIN, Q_MIN);
		send_point(Q_MIN, 0);
		send_point(0, Q_MIN);
		send_point(Q_MAX, Q_MIN);
		send_point('1, '1);
		send_point(ONE / 4, ONE / 2);
		drain();

		c = sb.cfg;
		c.mode = MODE_JULIA;
		c.max_iterations = 100;
		c.seed_re = -(ONE / 5 * 4);
		c.seed_im = ONE / 1000 * 156;
		write_config(c);
		send_point(0, 0);
		send_point(ONE / 2, -(ONE / 2));
		send_point(Q_MIN, Q_MAX);
		drain();

		c.mode = MODE_JULIA_B;
		c.max_iterations = 50;
		c.seed_re = ONE / 10 * 3;
		c.seed_im = -(ONE / 5);
		c.rot_xx = 0;
		c.rot_xy = -ONE;
		c.rot_yx = ONE;
		c.rot_yy = 0;
		write_config(c);
		send_point(ONE / 10, ONE / 5);
		send_point(-(ONE / 2), ONE / 2);
		drain();

		c.mode = MODE_SPARE;
		c.max_iterations = 20;
		c.rot_xx = Q_MAX;
		c.rot_xy = Q_MAX;
		c.rot_yx = Q_MIN;
		c.rot_yy = Q_MAX;
		write_config(c);
		send_point(ONE / 1000, ONE / 1000);
		send_point(-(ONE / 1000), ONE / 1000);
		drain();

		c.mode = MODE_MANDEL;
		c.max_iterations = 0;
		c.seed_re = 0;
		c.seed_im = 0;
		c.rot_xx = ONE;
		c.rot_xy = 0;
		c.rot_yx = 0;
		c.rot_yy = ONE;
		write_config(c);
		send_point(0, 0);
		send_point(Q_MIN, Q_MIN);
		drain();

		c.max_iterations = 1;
		write_config(c);
		send_point(0, 0);
		send_point(3 * ONE, 0);
		drain();

		c.max_iterations = 16'hFFFF;
		write_config(c);
		send_point(0, 0);
		drain();

		c.mode = MODE_JULIA;
		c.seed_re = Q_MIN;
		c.seed_im = Q_MIN;
		c.rot_xx = Q_MIN;
		c.rot_xy = Q_MIN;
		c.rot_yx = Q_MIN;
		c.rot_yy = Q_MIN;
		write_config(c);
		send_point(0, 0);
		drain();

		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			int unsigned r;
			r = $urandom_range(0, 99);
			c.mode = MODE_W'($urandom_range(0, 3));
			if (r < 70)
				c.max_iterations = REM_W'($urandom_range(1, 40));
			else if (r < 90)
				c.max_iterations = REM_W'($urandom_range(41, 255));
			else if (r < 95)
				c.max_iterations = 0;
			else
				c.max_iterations = REM_W'($urandom_range(256, 400));
			c.seed_re = rand_coord();
			c.seed_im = rand_coord();
			c.rot_xx = rand_coef();
			c.rot_xy = rand_coef();
			c.rot_yx = rand_coef();
			c.rot_yy = rand_coef();
			write_config(c);
			steady = ($urandom_range(0, 3) == 0);
			if (phase == 0)
				hold_results = 1'b1;
			n = $urandom_range(40, 120);
			for (int k = 0; k < n; k++) begin
				if (phase == 1 && k == n / 2)
					drain();
				send_point(rand_coord(), rand_coord());
			end
			drain();
			sent += n;
			phase++;
		end
		steady = 1'b0;
		repeat (600) @(posedge clk);

		if (sb.failed())
			$display("rotating_seed_escape_time_iteration_tb failed");
		else
			$display("rotating_seed_escape_time_iteration_tb passed");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/rsei_pkg.sv
hw/rtl/rsei_ifs.sv
hw/rtl/rsei_front.sv
hw/rtl/rsei_fifo.sv
hw/rtl/rsei_engine.sv
hw/rtl/rotating_seed_escape_time_iteration.sv
hw/rtl/rsei_checker.sv
bench/rotating_seed_escape_time_iteration_tb.sv
